[hdl/plob_pkg.sv]
// ----------------------------------------------------------------------------
// plob_pkg
// shared types for the price level order book matcher
// ----------------------------------------------------------------------------
package plob_pkg;

    typedef enum logic [1:0] {
        CMD_BUY_LIMIT   = 2'd0,
        CMD_SELL_LIMIT  = 2'd1,
        CMD_BUY_MARKET  = 2'd2,
        CMD_SELL_MARKET = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        OP_NOP      = 3'd0,
        OP_ADD_BID  = 3'd1,
        OP_ADD_ASK  = 3'd2,
        OP_MKT_BUY  = 3'd3,
        OP_MKT_SELL = 3'd4
    } op_t;

    localparam int TICK_W  = 8;
    localparam int SHARE_W = 24;
    localparam logic [SHARE_W-1:0] TRADE_MAX = {SHARE_W{1'b1}};

    typedef struct packed {
        logic [1:0]         command;
        logic [TICK_W-1:0]  price_tick;
        logic [SHARE_W-1:0] share_count;
    } in_t;

    typedef struct packed {
        logic [TICK_W-1:0]  best_bid;
        logic               bid_present;
        logic [TICK_W-1:0]  best_ask;
        logic               ask_present;
        logic [TICK_W-1:0]  spread;
        logic [SHARE_W-1:0] traded_shares;
    } out_t;

    typedef struct packed {
        op_t                op;
        logic [TICK_W-1:0]  tick;
        logic [SHARE_W-1:0] shares;
    } op_item_t;

endpackage

[hdl/plob_front.sv]
// ----------------------------------------------------------------------------
// plob_front
// accepts orders, classifies them into book operations, two entry queue
// ----------------------------------------------------------------------------
module plob_front #(
    parameter int PRICE_LEVELS = 256
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  plob_pkg::in_t      s_data,
    output logic               q_valid,
    input  logic               q_ready,
    output plob_pkg::op_item_t q_item
);

    plob_pkg::op_item_t entry_reg [2];
    logic               wr_ptr_reg, wr_ptr_next;
    logic               rd_ptr_reg, rd_ptr_next;
    logic [1:0]         count_reg, count_next;
    plob_pkg::op_item_t item;
    logic               tick_ok;
    logic               push, pop;

    always_comb begin
        tick_ok     = 32'(s_data.price_tick) < PRICE_LEVELS;
        item.tick   = s_data.price_tick;
        item.shares = s_data.share_count;
        item.op     = plob_pkg::OP_NOP;
        unique case (plob_pkg::cmd_t'(s_data.command))
            plob_pkg::CMD_BUY_LIMIT: begin
                if (tick_ok && s_data.share_count != '0) item.op = plob_pkg::OP_ADD_BID;
            end
            plob_pkg::CMD_SELL_LIMIT: begin
                if (tick_ok && s_data.share_count != '0) item.op = plob_pkg::OP_ADD_ASK;
            end
            plob_pkg::CMD_BUY_MARKET: begin
                if (s_data.share_count != '0) item.op = plob_pkg::OP_MKT_BUY;
            end
            plob_pkg::CMD_SELL_MARKET: begin
                if (s_data.share_count != '0) item.op = plob_pkg::OP_MKT_SELL;
            end
            default: item.op = plob_pkg::OP_NOP;
        endcase
    end

    assign s_ready = count_reg != 2'd2;
    assign q_valid = count_reg != 2'd0;
    assign q_item  = entry_reg[rd_ptr_reg];
    assign push    = s_valid && s_ready;
    assign pop     = q_valid && q_ready;

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) entry_reg[wr_ptr_reg] <= item;
    end

endmodule

[hdl/plob_back.sv]
// ----------------------------------------------------------------------------
// plob_back
// executes book operations on the bid and ask level memories
// ----------------------------------------------------------------------------
module plob_back #(
    parameter int PRICE_LEVELS = 256,
    parameter int QTY_WIDTH    = 32
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               q_valid,
    output logic               q_ready,
    input  plob_pkg::op_item_t q_item,
    output logic               m_valid,
    input  logic               m_ready,
    output plob_pkg::out_t     m_data
);

    localparam int TW  = $clog2(PRICE_LEVELS);
    localparam int QW  = QTY_WIDTH;
    localparam int SW  = ((QW > plob_pkg::SHARE_W) ? QW : plob_pkg::SHARE_W) + 1;
    localparam int TSW = SW + 1;
    localparam logic [QW-1:0] QMAX = {QW{1'b1}};
    localparam logic [TW-1:0] TOP  = TW'(PRICE_LEVELS - 1);

    typedef enum logic [12:0] {
        S_CLEAR     = 13'h0001,
        S_IDLE      = 13'h0002,
        S_ADD_RD    = 13'h0004,
        S_ADD_WR    = 13'h0008,
        S_MATCH_CHK = 13'h0010,
        S_MATCH_WR  = 13'h0020,
        S_SCAN_BID  = 13'h0040,
        S_SCAN_ASK  = 13'h0080,
        S_MKT_CHK   = 13'h0100,
        S_MKT_WR    = 13'h0200,
        S_REST_RD   = 13'h0400,
        S_REST_WR   = 13'h0800,
        S_DONE      = 13'h1000
    } state_t;

    state_t                       state_reg, state_next;
    plob_pkg::op_t                op_reg, op_next;
    logic [TW-1:0]                tick_reg, tick_next;
    logic [plob_pkg::SHARE_W-1:0] shares_reg, shares_next;
    logic [plob_pkg::SHARE_W-1:0] traded_reg, traded_next;
    logic [TW-1:0]                bb_reg, bb_next;
    logic                         bp_reg, bp_next;
    logic [TW-1:0]                ba_reg, ba_next;
    logic                         ap_reg, ap_next;
    logic [TW-1:0]                last_reg, last_next;
    logic                         swept_reg, swept_next;
    logic                         need_ask_reg, need_ask_next;
    logic                         mkt_reg, mkt_next;
    logic [TW-1:0]                scan_ptr_reg, scan_ptr_next;
    logic [TW-1:0]                chk_ptr_reg, chk_ptr_next;
    logic                         chk_valid_reg, chk_valid_next;
    logic [TW-1:0]                clr_ptr_reg, clr_ptr_next;
    logic                         out_valid_reg, out_valid_next;
    plob_pkg::out_t               out_reg, out_next;

    logic [QW-1:0] bid_mem [PRICE_LEVELS];
    logic [QW-1:0] ask_mem [PRICE_LEVELS];
    logic [QW-1:0] bid_rd_reg, ask_rd_reg;
    logic          bid_re, ask_re, bid_we, ask_we;
    logic [TW-1:0] bid_raddr, ask_raddr, bid_waddr, ask_waddr;
    logic [QW-1:0] bid_wdata, ask_wdata;

    logic          buy;
    logic [QW-1:0] side_rd, opp_rd, own_rd;
    logic [SW-1:0] sum_x, opp_x, sh_x, q_x;
    logic [QW-1:0] sat_q, mq, rem_bid, rem_ask, rem_opp;
    logic [TSW-1:0] tsum;
    logic [plob_pkg::SHARE_W-1:0] traded_add;
    logic          nb, na;
    state_t        ret_state;
    logic [TW-1:0] diff;
    logic          can_load;

    assign q_ready  = state_reg == S_IDLE;
    assign m_valid  = out_valid_reg;
    assign m_data   = out_reg;
    assign buy      = op_reg == plob_pkg::OP_MKT_BUY;
    assign can_load = !out_valid_reg || m_ready;

    always_comb begin
        side_rd = (op_reg == plob_pkg::OP_ADD_BID) ? bid_rd_reg : ask_rd_reg;
        opp_rd  = buy ? ask_rd_reg : bid_rd_reg;
        own_rd  = buy ? bid_rd_reg : ask_rd_reg;
        sum_x   = SW'(state_reg == S_REST_WR ? own_rd : side_rd) + SW'(shares_reg);
        sat_q   = (sum_x > SW'(QMAX)) ? QMAX : QW'(sum_x);
        opp_x   = SW'(opp_rd);
        sh_x    = SW'(shares_reg);
        mq      = (bid_rd_reg < ask_rd_reg) ? bid_rd_reg : ask_rd_reg;
        rem_bid = bid_rd_reg - mq;
        rem_ask = ask_rd_reg - mq;
        q_x     = (state_reg == S_MKT_WR) ? ((opp_x < sh_x) ? opp_x : sh_x) : SW'(mq);
        rem_opp = QW'(opp_x - q_x);
        tsum    = TSW'(traded_reg) + TSW'(q_x);
        traded_add = (tsum > TSW'(plob_pkg::TRADE_MAX)) ? plob_pkg::TRADE_MAX
                                                        : plob_pkg::SHARE_W'(tsum);
        ret_state = mkt_reg ? S_MKT_CHK : S_MATCH_CHK;
        diff      = ba_reg - bb_reg;
    end

    always_comb begin
        state_next     = state_reg;
        op_next        = op_reg;
        tick_next      = tick_reg;
        shares_next    = shares_reg;
        traded_next    = traded_reg;
        bb_next        = bb_reg;
        bp_next        = bp_reg;
        ba_next        = ba_reg;
        ap_next        = ap_reg;
        last_next      = last_reg;
        swept_next     = swept_reg;
        need_ask_next  = need_ask_reg;
        mkt_next       = mkt_reg;
        scan_ptr_next  = scan_ptr_reg;
        chk_ptr_next   = chk_ptr_reg;
        chk_valid_next = chk_valid_reg;
        clr_ptr_next   = clr_ptr_reg;
        out_next       = out_reg;
        out_valid_next = (out_valid_reg && !m_ready) ? 1'b1 : 1'b0;
        bid_re = 1'b0; ask_re = 1'b0; bid_we = 1'b0; ask_we = 1'b0;
        bid_raddr = bb_reg; ask_raddr = ba_reg;
        bid_waddr = bb_reg; ask_waddr = ba_reg;
        bid_wdata = '0;     ask_wdata = '0;
        nb = 1'b0; na = 1'b0;

        unique case (state_reg)
            S_CLEAR: begin
                bid_we = 1'b1; ask_we = 1'b1;
                bid_waddr = clr_ptr_reg; ask_waddr = clr_ptr_reg;
                clr_ptr_next = clr_ptr_reg + 1'b1;
                if (clr_ptr_reg == TOP) state_next = S_IDLE;
            end
            S_IDLE: begin
                if (q_valid) begin
                    op_next     = q_item.op;
                    tick_next   = TW'(q_item.tick);
                    shares_next = q_item.shares;
                    traded_next = '0;
                    swept_next  = 1'b0;
                    unique case (q_item.op)
                        plob_pkg::OP_ADD_BID,
                        plob_pkg::OP_ADD_ASK:  state_next = S_ADD_RD;
                        plob_pkg::OP_MKT_BUY,
                        plob_pkg::OP_MKT_SELL: state_next = S_MKT_CHK;
                        default:               state_next = S_DONE;
                    endcase
                end
            end
            S_ADD_RD: begin
                bid_re = 1'b1; ask_re = 1'b1;
                bid_raddr = tick_reg; ask_raddr = tick_reg;
                state_next = S_ADD_WR;
            end
            S_ADD_WR: begin
                mkt_next = 1'b0;
                if (op_reg == plob_pkg::OP_ADD_BID) begin
                    bid_we = 1'b1; bid_waddr = tick_reg; bid_wdata = sat_q;
                    if (!bp_reg || tick_reg > bb_reg) begin
                        bb_next = tick_reg; bp_next = 1'b1;
                    end
                end else begin
                    ask_we = 1'b1; ask_waddr = tick_reg; ask_wdata = sat_q;
                    if (!ap_reg || tick_reg < ba_reg) begin
                        ba_next = tick_reg; ap_next = 1'b1;
                    end
                end
                state_next = S_MATCH_CHK;
            end
            S_MATCH_CHK: begin
                if (bp_reg && ap_reg && bb_reg >= ba_reg) begin
                    bid_re = 1'b1; ask_re = 1'b1;
                    state_next = S_MATCH_WR;
                end else begin
                    state_next = S_DONE;
                end
            end
            S_MATCH_WR: begin
                bid_we = 1'b1; bid_wdata = rem_bid;
                ask_we = 1'b1; ask_wdata = rem_ask;
                traded_next = traded_add;
                nb = rem_bid == '0;
                na = rem_ask == '0;
            end
            S_MKT_CHK: begin
                mkt_next = 1'b1;
                if (shares_reg == '0) begin
                    state_next = S_DONE;
                end else if (!(buy ? ap_reg : bp_reg)) begin
                    state_next = swept_reg ? S_REST_RD : S_DONE;
                end else begin
                    if (buy) ask_re = 1'b1;
                    else     bid_re = 1'b1;
                    state_next = S_MKT_WR;
                end
            end
            S_MKT_WR: begin
                if (buy) begin
                    ask_we = 1'b1; ask_wdata = rem_opp;
                    na = rem_opp == '0;
                end else begin
                    bid_we = 1'b1; bid_wdata = rem_opp;
                    nb = rem_opp == '0;
                end
                shares_next = plob_pkg::SHARE_W'(sh_x - q_x);
                last_next   = buy ? ba_reg : bb_reg;
                swept_next  = 1'b1;
                traded_next = traded_add;
            end
            S_SCAN_BID: begin
                if (chk_valid_reg && (bid_rd_reg != '0 || chk_ptr_reg == '0)) begin
                    bb_next        = chk_ptr_reg;
                    bp_next        = bid_rd_reg != '0;
                    chk_valid_next = 1'b0;
                    if (need_ask_reg) begin
                        scan_ptr_next = ba_reg + 1'b1;
                        state_next    = S_SCAN_ASK;
                    end else begin
                        state_next = ret_state;
                    end
                end else begin
                    bid_re = 1'b1; bid_raddr = scan_ptr_reg;
                    chk_ptr_next   = scan_ptr_reg;
                    chk_valid_next = 1'b1;
                    scan_ptr_next  = scan_ptr_reg - 1'b1;
                end
            end
            S_SCAN_ASK: begin
                if (chk_valid_reg && (ask_rd_reg != '0 || chk_ptr_reg == TOP)) begin
                    ba_next        = chk_ptr_reg;
                    ap_next        = ask_rd_reg != '0;
                    chk_valid_next = 1'b0;
                    need_ask_next  = 1'b0;
                    state_next     = ret_state;
                end else begin
                    ask_re = 1'b1; ask_raddr = scan_ptr_reg;
                    chk_ptr_next   = scan_ptr_reg;
                    chk_valid_next = 1'b1;
                    scan_ptr_next  = scan_ptr_reg + 1'b1;
                end
            end
            S_REST_RD: begin
                bid_re = 1'b1; ask_re = 1'b1;
                bid_raddr = last_reg; ask_raddr = last_reg;
                state_next = S_REST_WR;
            end
            S_REST_WR: begin
                if (buy) begin
                    bid_we = 1'b1; bid_waddr = last_reg; bid_wdata = sat_q;
                    if (!bp_reg || last_reg > bb_reg) begin
                        bb_next = last_reg; bp_next = 1'b1;
                    end
                end else begin
                    ask_we = 1'b1; ask_waddr = last_reg; ask_wdata = sat_q;
                    if (!ap_reg || last_reg < ba_reg) begin
                        ba_next = last_reg; ap_next = 1'b1;
                    end
                end
                state_next = S_DONE;
            end
            S_DONE: begin
                if (can_load) begin
                    out_valid_next        = 1'b1;
                    out_next.best_bid     = bp_reg ? plob_pkg::TICK_W'(bb_reg) : '0;
                    out_next.bid_present  = bp_reg;
                    out_next.best_ask     = ap_reg ? plob_pkg::TICK_W'(ba_reg) : '0;
                    out_next.ask_present  = ap_reg;
                    out_next.spread       = '0;
                    if (bp_reg && ap_reg) begin
                        out_next.spread = (32'(diff) > 255) ? 8'd255
                                                            : plob_pkg::TICK_W'(diff);
                    end
                    out_next.traded_shares = traded_reg;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase

        // level emptied: rescan from the next tick, or the side is gone at the edge
        if (state_reg == S_MATCH_WR || state_reg == S_MKT_WR) begin
            if (nb && bb_reg == '0) begin
                bp_next = 1'b0; nb = 1'b0;
            end
            if (na && ba_reg == TOP) begin
                ap_next = 1'b0; na = 1'b0;
            end
            need_ask_next  = na;
            chk_valid_next = 1'b0;
            scan_ptr_next  = nb ? (bb_reg - 1'b1) : (ba_reg + 1'b1);
            state_next     = nb ? S_SCAN_BID : (na ? S_SCAN_ASK : ret_state);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_CLEAR;
            clr_ptr_reg   <= '0;
            bp_reg        <= 1'b0;
            ap_reg        <= 1'b0;
            chk_valid_reg <= 1'b0;
            need_ask_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            clr_ptr_reg   <= clr_ptr_next;
            bp_reg        <= bp_next;
            ap_reg        <= ap_next;
            chk_valid_reg <= chk_valid_next;
            need_ask_reg  <= need_ask_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg       <= op_next;
        tick_reg     <= tick_next;
        shares_reg   <= shares_next;
        traded_reg   <= traded_next;
        bb_reg       <= bb_next;
        ba_reg       <= ba_next;
        last_reg     <= last_next;
        swept_reg    <= swept_next;
        mkt_reg      <= mkt_next;
        scan_ptr_reg <= scan_ptr_next;
        chk_ptr_reg  <= chk_ptr_next;
        out_reg      <= out_next;
    end

    always_ff @(posedge aclk) begin
        if (bid_we) bid_mem[bid_waddr] <= bid_wdata;
        if (bid_re) bid_rd_reg <= bid_mem[bid_raddr];
    end

    always_ff @(posedge aclk) begin
        if (ask_we) ask_mem[ask_waddr] <= ask_wdata;
        if (ask_re) ask_rd_reg <= ask_mem[ask_raddr];
    end

endmodule

[hdl/price_level_order_book_matcher.sv]
// ----------------------------------------------------------------------------
// price_level_order_book_matcher
// price level limit order book with matching of crossed levels
// ----------------------------------------------------------------------------
// input channel s_*: one order per transaction (command, price_tick,
// share_count); output channel m_*: one result per order with the best bid,
// best ask, their presence, the spread and the shares traded.
// orders pass a two entry queue into the execution engine, which walks the
// bid and ask level memories one port access per cycle.
// a limit order that does not cross passes S_ADD_RD, S_ADD_WR and S_MATCH_CHK
// before S_DONE registers its result; each match or sweep step is a read
// state and a write state, and a step that empties a level adds a scan that
// reads one tick after another until a filled level or the edge of the book.
// one order is executed at a time; the queue takes orders meanwhile until
// both entries are full. after reset a clearing pass zeroes both memories;
// orders are queued but not executed until it ends.
// when the receiver stalls, the result waits in the output register and the
// engine holds the next finished result until it is taken.
// ----------------------------------------------------------------------------
module price_level_order_book_matcher #(
    parameter int PRICE_LEVELS = 256,
    parameter int QTY_WIDTH    = 32
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  plob_pkg::in_t  s_data,
    output logic           m_valid,
    input  logic           m_ready,
    output plob_pkg::out_t m_data
);

    logic               q_valid;
    logic               q_ready;
    plob_pkg::op_item_t q_item;

    plob_front #(
        .PRICE_LEVELS(PRICE_LEVELS)
    ) u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_item  (q_item)
    );

    plob_back #(
        .PRICE_LEVELS(PRICE_LEVELS),
        .QTY_WIDTH   (QTY_WIDTH)
    ) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_item  (q_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

[hdl/plob_checker.sv]
// ----------------------------------------------------------------------------
// plob_checker
// port level checks on the result channel of the order book matcher
// ----------------------------------------------------------------------------
module plob_checker (
    input logic           aclk,
    input logic           aresetn,
    input logic           m_valid,
    input logic           m_ready,
    input plob_pkg::out_t m_data
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    a_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.bid_present || m_data.best_bid == '0) &&
                    (m_data.ask_present || m_data.best_ask == '0))
        else $error("empty side reports a tick");

    a_uncrossed: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.bid_present && m_data.ask_present |->
            m_data.best_ask > m_data.best_bid &&
            m_data.spread == m_data.best_ask - m_data.best_bid)
        else $error("book left crossed or spread wrong");

    a_spread_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !(m_data.bid_present && m_data.ask_present) |-> m_data.spread == '0)
        else $error("spread with one side empty");

endmodule

bind price_level_order_book_matcher plob_checker u_plob_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
